>>> src/amu_pkg.sv
`timescale 1ns / 1ps

package amu_pkg;

    // Field and state widths.
    localparam int DATA_W  = 40;
    localparam int AMT_W   = 50;
    localparam int ARENA_W = 51;
    localparam int HDR_W   = 16;
    localparam int REM_W   = ARENA_W + 2;

    // Saturation limits.
    localparam logic [ARENA_W-1:0] ARENA_MAX = {ARENA_W{1'b1}};
    localparam logic [AMT_W-1:0]   AMT_MAX   = {AMT_W{1'b1}};

    // Operation selector codes.
    localparam logic [1:0] FUNC_TRY_ADD = 2'd0;
    localparam logic [1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_PREP,
        ST_ADD_APPLY,
        ST_RM_SUB,
        ST_RM_INIT,
        ST_RM_LOOP,
        ST_CLEAR,
        ST_RND_INIT,
        ST_RND_STEP,
        ST_SUM_A,
        ST_SUM_B,
        ST_SUM_C,
        ST_DONE
    } amu_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic add_prep;
        logic add_apply;
        logic rm_sub;
        logic rm_init;
        logic rm_step;
        logic clear;
        logic rnd_init;
        logic rnd_step;
        logic sum_a;
        logic sum_b;
        logic sum_c;
        logic finish;
    } amu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       busy;
        logic       rnd_done;
        logic       out_free;
    } amu_status_t;

endpackage

>>> src/amu_ctrl.sv
`timescale 1ns / 1ps

module amu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  amu_pkg::amu_status_t status,
    output amu_pkg::amu_cmd_t    cmd
);
    import amu_pkg::*;

    amu_state_t state_reg;
    amu_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.func)
                    FUNC_TRY_ADD: state_next = ST_ADD_PREP;
                    FUNC_REMOVE:  state_next = ST_RM_SUB;
                    FUNC_RESET:   state_next = ST_CLEAR;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_ADD_PREP:
            begin
                cmd.add_prep = 1'b1;
                state_next   = ST_ADD_APPLY;
            end
            ST_ADD_APPLY:
            begin
                cmd.add_apply = 1'b1;
                state_next    = ST_RND_INIT;
            end
            ST_RM_SUB:
            begin
                cmd.rm_sub = 1'b1;
                state_next = ST_RM_INIT;
            end
            ST_RM_INIT:
            begin
                cmd.rm_init = 1'b1;
                state_next  = ST_RM_LOOP;
            end
            ST_RM_LOOP:
            begin
                // Lanes step together until each fits or steps run out.
                if (status.busy)
                begin
                    cmd.rm_step = 1'b1;
                end
                else
                begin
                    state_next = ST_RND_INIT;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_RND_INIT;
            end
            ST_RND_INIT:
            begin
                cmd.rnd_init = 1'b1;
                state_next   = ST_RND_STEP;
            end
            ST_RND_STEP:
            begin
                if (status.rnd_done)
                begin
                    state_next = ST_SUM_A;
                end
                else
                begin
                    cmd.rnd_step = 1'b1;
                end
            end
            ST_SUM_A:
            begin
                cmd.sum_a  = 1'b1;
                state_next = ST_SUM_B;
            end
            ST_SUM_B:
            begin
                cmd.sum_b  = 1'b1;
                state_next = ST_SUM_C;
            end
            ST_SUM_C:
            begin
                cmd.sum_c  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/amu_datapath.sv
`timescale 1ns / 1ps

module amu_datapath #(
    parameter int MIN_CAP   = 4194304,
    parameter int PAGE_SIZE = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  amu_pkg::amu_cmd_t                 cmd,
    output amu_pkg::amu_status_t              status,
    input  logic [1:0]                        in_func,
    input  logic [amu_pkg::DATA_W-1:0]        in_graph_bytes,
    input  logic [amu_pkg::DATA_W-1:0]        in_vector_bytes,
    input  logic [amu_pkg::AMT_W-1:0]         in_tracker_amount,
    input  logic [amu_pkg::AMT_W-1:0]         overall_limit,
    input  logic [amu_pkg::HDR_W-1:0]         header_bytes,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_accepted,
    output logic [amu_pkg::AMT_W-1:0]         out_total_memory,
    output logic signed [amu_pkg::ARENA_W-1:0] out_tracker_delta
);
    import amu_pkg::*;

    // Page remainder is taken DIGIT bits at a time, most significant first.
    localparam int DIGIT  = 4;
    localparam int NSTEP  = (ARENA_W + DIGIT - 1) / DIGIT;
    localparam int SH_W   = NSTEP * DIGIT;
    localparam int CW     = $clog2(NSTEP + 1);
    localparam int RW     = $clog2(PAGE_SIZE) + 1;
    localparam int UP_W   = ARENA_W + 1;
    localparam int MEM_W  = ARENA_W + 2;
    localparam int SUM_W  = ARENA_W + 3;
    localparam int ITER_W = 7;

    localparam logic [RW-1:0]      PAGE      = RW'(PAGE_SIZE);
    localparam logic [ARENA_W-1:0] FIRST_CAP = ARENA_W'(MIN_CAP) << 1;
    localparam logic [ITER_W-1:0]  ITER_LAST = {ITER_W{1'b1}};

    function automatic logic [ARENA_W-1:0] sat_add(input logic [ARENA_W-1:0] a,
                                                   input logic [ARENA_W-1:0] b);
        logic [ARENA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ARENA_W] ? ARENA_MAX : s[ARENA_W-1:0];
    endfunction

    function automatic logic [ARENA_W-1:0] sat_double(input logic [ARENA_W-1:0] c);
        return c[ARENA_W-1] ? ARENA_MAX : {c[ARENA_W-2:0], 1'b0};
    endfunction

    function automatic logic signed [ARENA_W-1:0] clamp_total(input logic [ARENA_W:0] v);
        logic signed [ARENA_W-1:0] r;
        if (v[ARENA_W] != v[ARENA_W-1])
        begin
            r = v[ARENA_W] ? {1'b1, {(ARENA_W-1){1'b0}}} : {1'b0, {(ARENA_W-1){1'b1}}};
        end
        else
        begin
            r = v[ARENA_W-1:0];
        end
        return r;
    endfunction

    // Block state.
    logic [ARENA_W-1:0]        comm_reg [2];
    logic [ARENA_W-1:0]        cap_reg  [2];
    logic [ARENA_W-1:0]        used_reg [2];
    logic signed [ARENA_W-1:0] tot_reg  [2];
    logic [AMT_W-1:0]          last_reg;

    // Latched item.
    logic [1:0]                func_reg;
    logic [DATA_W-1:0]         bytes_reg [2];
    logic [AMT_W-1:0]          tracker_reg;

    // Working copy of the arenas.
    logic [ARENA_W-1:0]        w_comm_reg [2];
    logic [ARENA_W-1:0]        w_cap_reg  [2];
    logic [ARENA_W-1:0]        w_used_reg [2];

    // Rebuild loop.
    logic signed [REM_W-1:0]   rem_reg   [2];
    logic signed [REM_W-1:0]   space_reg [2];
    logic [1:0]                busy_reg;
    logic [ITER_W-1:0]         iter_reg;

    // Page rounding and totals.
    logic [SH_W-1:0]           sh_reg [2];
    logic [RW-1:0]             r_reg  [2];
    logic [CW-1:0]             rcnt_reg;
    logic [UP_W-1:0]           up_reg  [2];
    logic [MEM_W-1:0]          mem_reg [2];
    logic [AMT_W-1:0]          total_reg;

    // Output register.
    logic                      out_valid_reg;
    logic                      out_acc_reg;
    logic [AMT_W-1:0]          out_total_reg;
    logic signed [ARENA_W-1:0] out_delta_reg;

    // Per-lane combinational results.
    logic [UP_W-1:0]           sum_ub    [2];
    logic                      add_wrap  [2];
    logic [ARENA_W-1:0]        used_add  [2];
    logic [ARENA_W-1:0]        used_hdr  [2];
    logic [ARENA_W-1:0]        comm_sum  [2];
    logic [ARENA_W-1:0]        cap_dbl   [2];
    logic signed [REM_W-1:0]   rem_diff  [2];
    logic signed [REM_W-1:0]   space_dbl [2];
    logic signed [ARENA_W-1:0] tot_add   [2];
    logic signed [ARENA_W-1:0] tot_sub   [2];
    logic                      tot_pos   [2];
    logic [RW-1:0]             r_next    [2];
    logic [RW-1:0]             pad       [2];

    logic [SUM_W-1:0]          tsum;
    logic [AMT_W-1:0]          total_next;
    logic [AMT_W:0]            limit_side;
    logic [AMT_W:0]            track_side;
    logic                      over;
    logic                      commit;
    logic signed [ARENA_W-1:0] delta_now;

    // Lane arithmetic: append, rebuild step, data totals and page remainder.
    always_comb
    begin
        logic [RW-1:0] t;
        logic [RW:0]   tt;
        logic [ARENA_W:0] tot_ext;
        logic [ARENA_W:0] byte_ext;
        for (int k = 0; k < 2; k++)
        begin
            sum_ub[k]   = {1'b0, w_used_reg[k]} + UP_W'(bytes_reg[k]);
            add_wrap[k] = sum_ub[k] >= {1'b0, w_cap_reg[k]};
            used_add[k] = sum_ub[k][ARENA_W] ? ARENA_MAX : sum_ub[k][ARENA_W-1:0];
            used_hdr[k] = ARENA_W'(header_bytes) + ARENA_W'(bytes_reg[k]);
            comm_sum[k] = sat_add(w_comm_reg[k], w_cap_reg[k]);
            cap_dbl[k]  = sat_double(w_cap_reg[k]);
            rem_diff[k] = rem_reg[k] - space_reg[k];
            space_dbl[k] = $signed({2'b00, cap_dbl[k]}) - $signed(REM_W'(header_bytes));

            tot_ext     = {tot_reg[k][ARENA_W-1], tot_reg[k]};
            byte_ext    = (ARENA_W + 1)'(bytes_reg[k]);
            tot_add[k]  = clamp_total(tot_ext + byte_ext);
            tot_sub[k]  = clamp_total(tot_ext - byte_ext);
            tot_pos[k]  = !tot_reg[k][ARENA_W-1] && (tot_reg[k] != '0);

            t = r_reg[k];
            for (int j = 0; j < DIGIT; j++)
            begin
                tt = {t, sh_reg[k][SH_W-1-j]};
                if (tt >= {1'b0, PAGE})
                begin
                    tt = tt - {1'b0, PAGE};
                end
                t = tt[RW-1:0];
            end
            r_next[k] = t;
            pad[k]    = (r_reg[k] == '0) ? '0 : PAGE - r_reg[k];
        end
    end

    // Grand total, limit check and the result of the item.
    always_comb
    begin
        tsum       = SUM_W'(mem_reg[0]) + SUM_W'(mem_reg[1]);
        total_next = (tsum > SUM_W'(AMT_MAX)) ? AMT_MAX : tsum[AMT_W-1:0];
        limit_side = {1'b0, overall_limit} + {1'b0, last_reg};
        track_side = {1'b0, tracker_reg} + {1'b0, total_reg};
        over       = (func_reg == FUNC_TRY_ADD) && (overall_limit != '0)
                     && (track_side > limit_side);
        commit     = ((func_reg == FUNC_TRY_ADD) && !over)
                     || (func_reg == FUNC_REMOVE) || (func_reg == FUNC_RESET);
        delta_now  = $signed({1'b0, total_reg}) - $signed({1'b0, last_reg});
    end

    // Block state and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                comm_reg[k] <= '0;
                cap_reg[k]  <= '0;
                used_reg[k] <= '0;
                tot_reg[k]  <= '0;
            end
            last_reg      <= '0;
            busy_reg      <= '0;
            iter_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rm_sub)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    tot_reg[k] <= tot_sub[k];
                end
            end
            if (cmd.clear)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    tot_reg[k] <= '0;
                end
            end
            if (cmd.rm_init)
            begin
                iter_reg <= '0;
                for (int k = 0; k < 2; k++)
                begin
                    busy_reg[k] <= tot_pos[k];
                end
            end
            // A lane stops when its data fits, nothing is left to pack or the step counter reaches its last value.
            if (cmd.rm_step)
            begin
                iter_reg <= iter_reg + 1'b1;
                for (int k = 0; k < 2; k++)
                begin
                    busy_reg[k] <= busy_reg[k] && (rem_diff[k] > 0)
                                   && (iter_reg != ITER_LAST);
                end
            end
            if (cmd.rnd_init)
            begin
                rcnt_reg <= CW'(NSTEP);
            end
            if (cmd.rnd_step)
            begin
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (commit)
                begin
                    last_reg <= total_reg;
                    for (int k = 0; k < 2; k++)
                    begin
                        comm_reg[k] <= w_comm_reg[k];
                        cap_reg[k]  <= w_cap_reg[k];
                        used_reg[k] <= w_used_reg[k];
                        if (func_reg == FUNC_TRY_ADD)
                        begin
                            tot_reg[k] <= tot_add[k];
                        end
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= in_func;
            bytes_reg[0] <= in_graph_bytes;
            bytes_reg[1] <= in_vector_bytes;
            tracker_reg  <= in_tracker_amount;
        end
        for (int k = 0; k < 2; k++)
        begin
            // A missing arena opens at the first capacity.
            if (cmd.add_prep)
            begin
                w_comm_reg[k] <= comm_reg[k];
                w_cap_reg[k]  <= (cap_reg[k] == '0) ? FIRST_CAP : cap_reg[k];
                w_used_reg[k] <= (cap_reg[k] == '0) ? ARENA_W'(header_bytes) : used_reg[k];
            end
            if (cmd.add_apply)
            begin
                if (add_wrap[k])
                begin
                    w_comm_reg[k] <= comm_sum[k];
                    w_cap_reg[k]  <= cap_dbl[k];
                    w_used_reg[k] <= used_hdr[k];
                end
                else
                begin
                    w_used_reg[k] <= used_add[k];
                end
            end
            if (cmd.clear)
            begin
                w_comm_reg[k] <= '0;
                w_cap_reg[k]  <= '0;
                w_used_reg[k] <= '0;
            end
            if (cmd.rm_init)
            begin
                w_comm_reg[k] <= '0;
                if (tot_pos[k])
                begin
                    w_cap_reg[k]  <= FIRST_CAP;
                    w_used_reg[k] <= ARENA_W'(header_bytes);
                end
                else
                begin
                    w_cap_reg[k]  <= '0;
                    w_used_reg[k] <= '0;
                end
                rem_reg[k]   <= REM_W'(tot_reg[k]);
                space_reg[k] <= $signed(REM_W'(FIRST_CAP)) - $signed(REM_W'(header_bytes));
            end
            // One rebuild step: fill the open arena or commit it and double.
            if (cmd.rm_step && busy_reg[k])
            begin
                if (rem_diff[k] < 0)
                begin
                    w_used_reg[k] <= w_used_reg[k] + rem_reg[k][ARENA_W-1:0];
                end
                else
                begin
                    rem_reg[k]    <= rem_diff[k];
                    w_comm_reg[k] <= comm_sum[k];
                    w_cap_reg[k]  <= cap_dbl[k];
                    w_used_reg[k] <= ARENA_W'(header_bytes);
                    space_reg[k]  <= space_dbl[k];
                end
            end
            if (cmd.rnd_init)
            begin
                sh_reg[k] <= SH_W'(w_used_reg[k]);
                r_reg[k]  <= '0;
            end
            if (cmd.rnd_step)
            begin
                sh_reg[k] <= sh_reg[k] << DIGIT;
                r_reg[k]  <= r_next[k];
            end
            if (cmd.sum_a)
            begin
                up_reg[k] <= UP_W'(w_used_reg[k]) + UP_W'(pad[k]);
            end
            if (cmd.sum_b)
            begin
                mem_reg[k] <= (w_cap_reg[k] == '0) ? '0
                              : MEM_W'(w_comm_reg[k]) + MEM_W'(up_reg[k]);
            end
        end
        if (cmd.sum_c)
        begin
            total_reg <= total_next;
        end
        if (cmd.finish)
        begin
            out_acc_reg   <= commit;
            out_total_reg <= commit ? total_reg : last_reg;
            out_delta_reg <= commit ? delta_now : '0;
        end
    end

    // Status and outputs.
    assign status.func       = func_reg;
    assign status.busy       = |busy_reg;
    assign status.rnd_done   = (rcnt_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_accepted      = out_acc_reg;
    assign out_total_memory  = out_total_reg;
    assign out_tracker_delta = out_delta_reg;

endmodule

>>> src/arena_memory_admission_unit.sv
// Operations: try_add, remove and reset each end with page rounding and the totals; remove
// first rebuilds the arenas, one doubling step per cycle, until each arena is packed
// or the step counter runs out. The unused selector skips straight to the result.
// Throughput: one item at a time; the next input transfer is taken once the result
// enters the output register, which holds it while the consumer stalls.
// Reset: rst_n is asynchronous, active low, and clears the arenas, totals and control state.
`timescale 1ns / 1ps

module arena_memory_admission_unit #(
    parameter int MIN_CAP   = 4194304,
    parameter int PAGE_SIZE = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // graph_bytes[39:0], vector_bytes[79:40],
                                        // tracker_amount[129:80], zero fill
    input  logic [1:0]   s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // total_memory[49:0], tracker_delta[100:50],
                                        // zero fill
    output logic [0:0]   m_axis_tuser,  // accepted[0]
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import amu_pkg::*;

    // Register selects taken from the 8-byte register address.
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_HEADER = 1'b1;

    logic [AMT_W-1:0]          limit_reg;
    logic [HDR_W-1:0]          header_reg;
    logic                      cfg_write;

    amu_cmd_t                  cmd;
    amu_status_t               status;

    logic                      out_accepted;
    logic [AMT_W-1:0]          out_total_memory;
    logic signed [ARENA_W-1:0] out_tracker_delta;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= '0;
            header_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3])
                REG_LIMIT:  limit_reg  <= pwdata[AMT_W-1:0];
                REG_HEADER: header_reg <= pwdata[HDR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[3])
            REG_LIMIT:  prdata = 64'(limit_reg);
            REG_HEADER: prdata = 64'(header_reg);
            default:    prdata = '0;
        endcase
    end

    amu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    amu_datapath #(
        .MIN_CAP   (MIN_CAP),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_func           (s_axis_tuser),
        .in_graph_bytes    (s_axis_tdata[39:0]),
        .in_vector_bytes   (s_axis_tdata[79:40]),
        .in_tracker_amount (s_axis_tdata[129:80]),
        .overall_limit     (limit_reg),
        .header_bytes      (header_reg),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_accepted      (out_accepted),
        .out_total_memory  (out_total_memory),
        .out_tracker_delta (out_tracker_delta)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, out_tracker_delta, out_total_memory};
    assign m_axis_tuser = out_accepted;

`ifndef SYNTHESIS
    // An input transfer starts work, so the block stops taking items.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item was in progress");

    // A refused or ignored item reports no change to the tracker.
    a_refused_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[100:50] == '0))
        else $error("nonzero tracker delta on a refused item");

    // A new result always leaves the block ready for the next item.
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while the controller was not idle");
`endif

endmodule
